// ----- rtl/wfa_pkg.sv -----
// Package for the weighted frame accumulator: widths, command codes,
// transaction payload structs and the per-lane product function.
// No dependencies; used by every module of the block except wfa_ram.
package wfa_pkg;

	localparam int PIX_W     = 16;
	localparam int CHAN_W    = 8;
	localparam int WEIGHT_W  = 9;
	localparam int ACC_W     = 16;
	localparam int LANES     = 4;
	localparam int FRAME_W   = PIX_W + 1;
	localparam int ACC_SHIFT = 8;
	localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(2 ** PIX_W);

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef logic [LANES-1:0][ACC_W-1:0]  acc_t;
	typedef logic [LANES-1:0][CHAN_W-1:0] bytes_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [PIX_W-1:0]    pixel_index;
		logic [CHAN_W-1:0]   chan0_in;
		logic [CHAN_W-1:0]   chan1_in;
		logic [CHAN_W-1:0]   chan2_in;
		logic [CHAN_W-1:0]   chan3_in;
		logic [WEIGHT_W-1:0] weight;
	} wfa_in_t;

	typedef struct packed {
		logic [PIX_W-1:0]  pixel_out_index;
		logic [CHAN_W-1:0] chan0_out;
		logic [CHAN_W-1:0] chan1_out;
		logic [CHAN_W-1:0] chan2_out;
		logic [CHAN_W-1:0] chan3_out;
	} wfa_out_t;

	// Control of the update stage.
	typedef struct packed {
		logic [1:0] command;
		logic       fwd_hit;
	} upd_ctl_t;

	// Channel byte times weight, kept modulo 2^ACC_W.
	function automatic logic [ACC_W-1:0] lane_product(input logic [CHAN_W-1:0] chan,
			input logic [WEIGHT_W-1:0] weight);
		logic [CHAN_W+WEIGHT_W-1:0] full;
		full = chan * weight;
		return full[ACC_W-1:0];
	endfunction

endpackage

// ----- rtl/wfa_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// Reads return the old contents when the same address is written in that cycle.
// No dependencies.
module wfa_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 64
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/wfa_update.sv -----
// Read-modify-write datapath of the accumulator: picks forwarded or stored
// lanes, adds or loads the products, and extracts the read-out bytes.
// Depends on wfa_pkg.
module wfa_update (
	input  wfa_pkg::upd_ctl_t ctl,
	input  wfa_pkg::acc_t     prod,
	input  wfa_pkg::acc_t     rd_data,
	input  wfa_pkg::acc_t     fwd_data,
	output wfa_pkg::acc_t     new_acc,
	output wfa_pkg::bytes_t   rd_bytes
);
	import wfa_pkg::*;

	acc_t cur;

	always_comb begin
		cur = ctl.fwd_hit ? fwd_data : rd_data;
		for (int k = 0; k < LANES; k++) begin
			if (ctl.command == CMD_CLEAR) begin
				new_acc[k] = prod[k];
			end else begin
				new_acc[k] = cur[k] + prod[k];
			end
			rd_bytes[k] = cur[k][ACC_SHIFT +: CHAN_W];
		end
	end

endmodule

// ----- rtl/weighted_frame_accumulator.sv -----
// Per-pixel weighted frame accumulator: four 16-bit lanes per pixel in one RAM.
// Depends on wfa_pkg, wfa_ram and wfa_update.
//
// One transaction is taken every clock cycle as long as read-out results are
// taken by the sink. A transaction reads its accumulator from the RAM on
// acceptance, and the next cycle adds or loads the products and writes back
// through the single write port; a read-out is then registered in the output
// register. Back-to-back transactions on the same pixel are handled by
// forwarding the value just written. Items beyond frame_pixels and the unused
// command are accepted and dropped. The RAM is not cleared after reset: an add
// or read-out on a pixel that was never cleared returns undefined data.
module weighted_frame_accumulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wfa_pkg::FRAME_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  wfa_pkg::wfa_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output wfa_pkg::wfa_out_t              out_data
);
	import wfa_pkg::*;

	logic [FRAME_W-1:0] frame_pixels_q;
	logic               valid_s1;
	logic [1:0]         cmd_s1;
	logic [PIX_W-1:0]   idx_s1;
	acc_t               prod_s1;
	logic               fwd_hit_s1;
	acc_t               fwd_data_s1;
	logic               out_valid_q;
	wfa_out_t           out_data_q;

	logic     accept;
	logic     keep;
	logic     s1_go;
	logic     wr_en;
	acc_t     prod;
	acc_t     rd_data;
	acc_t     new_acc;
	bytes_t   rd_bytes;
	upd_ctl_t ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FRAME_RESET;
		end else if (cfg_we) begin
			frame_pixels_q <= cfg_data;
		end
	end

	// A read-out can only leave the stage when the output register frees up.
	assign s1_go    = !(cmd_s1 == CMD_READ) || !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;
	assign keep     = ({1'b0, in_data.pixel_index} < frame_pixels_q) &&
	                  (in_data.command == CMD_CLEAR || in_data.command == CMD_ADD ||
	                   in_data.command == CMD_READ);
	assign wr_en    = valid_s1 && (cmd_s1 == CMD_CLEAR || cmd_s1 == CMD_ADD);

	always_comb begin
		prod[0] = lane_product(in_data.chan0_in, in_data.weight);
		prod[1] = lane_product(in_data.chan1_in, in_data.weight);
		prod[2] = lane_product(in_data.chan2_in, in_data.weight);
		prod[3] = lane_product(in_data.chan3_in, in_data.weight);
	end

	wfa_ram #(
		.ADDR_W(PIX_W),
		.DATA_W(LANES * ACC_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(idx_s1),
		.wr_data(new_acc),
		.rd_en  (accept),
		.rd_addr(in_data.pixel_index),
		.rd_data(rd_data)
	);

	assign ctl.command = cmd_s1;
	assign ctl.fwd_hit = fwd_hit_s1;

	wfa_update u_update (
		.ctl     (ctl),
		.prod    (prod_s1),
		.rd_data (rd_data),
		.fwd_data(fwd_data_s1),
		.new_acc (new_acc),
		.rd_bytes(rd_bytes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && keep;
		end
	end

	// The RAM read misses a write made in the same cycle, so that value is
	// captured here and used in its place.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1      <= in_data.command;
			idx_s1      <= in_data.pixel_index;
			prod_s1     <= prod;
			fwd_hit_s1  <= wr_en && (idx_s1 == in_data.pixel_index);
			fwd_data_s1 <= new_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && cmd_s1 == CMD_READ && s1_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && cmd_s1 == CMD_READ && s1_go) begin
			out_data_q.pixel_out_index <= idx_s1;
			out_data_q.chan0_out       <= rd_bytes[0];
			out_data_q.chan1_out       <= rd_bytes[1];
			out_data_q.chan2_out       <= rd_bytes[2];
			out_data_q.chan3_out       <= rd_bytes[3];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- rtl/wfa_checker.sv -----
// Port-level checks for the weighted frame accumulator and the bind that
// attaches them to the top level. Depends on wfa_pkg.
module wfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_we,
	input logic [wfa_pkg::FRAME_W-1:0] cfg_data,
	input logic                        in_valid,
	input logic                        in_ready,
	input wfa_pkg::wfa_in_t            in_data,
	input logic                        out_valid,
	input logic                        out_ready,
	input wfa_pkg::wfa_out_t           out_data
);
	import wfa_pkg::*;

	logic [FRAME_W-1:0] frame_q;
	logic               read_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= FRAME_RESET;
		end else if (cfg_we) begin
			frame_q <= cfg_data;
		end
	end

	assign read_hit = in_valid && in_ready && in_data.command == CMD_READ &&
	                  ({1'b0, in_data.pixel_index} < frame_q);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result payload changed while stalled");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		read_hit ##1 (!out_valid || out_ready) |=>
			out_valid && out_data.pixel_out_index == $past(in_data.pixel_index, 2))
		else $error("read-out result missing or with the wrong index");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transaction");

endmodule

bind weighted_frame_accumulator wfa_checker u_wfa_checker (.*);

// ----- dv/tb_weighted_frame_accumulator.sv -----
// Self-checking testbench for weighted_frame_accumulator: a directed table, then
// random clear/add/read-out sequences under several frame sizes and idle patterns.
// Depends on rtl/wfa_pkg.sv and rtl/weighted_frame_accumulator.sv.
module tb_weighted_frame_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	import wfa_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int HANG_LIMIT = 4000;
	localparam int PIPE_DRAIN = 6;

	typedef struct {
		wfa_in_t  px;
		bit       typed;
		wfa_out_t rd;
	} table_row_t;

	bit clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [FRAME_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	wfa_in_t in_data;
	logic out_valid;
	logic out_ready;
	wfa_out_t out_data;

	// Predictor state: accumulator lanes of every pixel written since reset.
	acc_t pixel_acc [int];
	logic [FRAME_W-1:0] frame_limit;
	wfa_out_t expected_pixels [$];
	int mismatch_count = 0;
	int snd_idle_pct;
	int rcv_idle_pct;
	int hot_pixels [6];
	table_row_t directed_rows [21];

	weighted_frame_accumulator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic wfa_in_t pix(input logic [1:0] cmd, input logic [PIX_W-1:0] idx,
			input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
			input logic [7:0] c3, input logic [WEIGHT_W-1:0] w);
		wfa_in_t px;
		px.command     = cmd;
		px.pixel_index = idx;
		px.chan0_in    = c0;
		px.chan1_in    = c1;
		px.chan2_in    = c2;
		px.chan3_in    = c3;
		px.weight      = w;
		return px;
	endfunction

	function automatic wfa_out_t blurred(input logic [PIX_W-1:0] idx, input logic [7:0] c0,
			input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
		return '{pixel_out_index: idx, chan0_out: c0, chan1_out: c1, chan2_out: c2,
			chan3_out: c3};
	endfunction

	// Applies one accepted transaction to the accumulator copy; returns 1 with the
	// blurred pixel when the transaction is a read-out that is carried out.
	function automatic bit predict_blur(input wfa_in_t px, output wfa_out_t rd);
		bytes_t chans;
		acc_t prod;
		acc_t lanes;
		int idx;
		chans = {px.chan3_in, px.chan2_in, px.chan1_in, px.chan0_in};
		idx = int'(px.pixel_index);
		rd = '0;
		if ({1'b0, px.pixel_index} >= frame_limit)
			return 1'b0;
		for (int k = 0; k < LANES; k++)
			prod[k] = 16'(32'(chans[k]) * 32'(px.weight));
		case (px.command)
			CMD_CLEAR: begin
				pixel_acc[idx] = prod;
			end
			CMD_ADD: begin
				lanes = pixel_acc[idx];
				for (int k = 0; k < LANES; k++)
					lanes[k] = lanes[k] + prod[k];
				pixel_acc[idx] = lanes;
			end
			CMD_READ: begin
				lanes = pixel_acc[idx];
				rd = blurred(px.pixel_index, lanes[0][15:8], lanes[1][15:8],
					lanes[2][15:8], lanes[3][15:8]);
				return 1'b1;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	// Random item: mostly in-frame traffic on a few hot pixels, where a pixel is
	// always cleared before it is added to or read; the rest is noise the block drops.
	function automatic wfa_in_t next_pixel();
		wfa_in_t px;
		int lim;
		int idx;
		int roll;
		lim = (frame_limit > FRAME_W'(65536)) ? 65536 : int'(frame_limit);
		px.chan0_in = 8'($urandom_range(255, 0));
		px.chan1_in = 8'($urandom_range(255, 0));
		px.chan2_in = 8'($urandom_range(255, 0));
		px.chan3_in = 8'($urandom_range(255, 0));
		if ($urandom_range(99, 0) < 80)
			px.weight = 9'($urandom_range(256, 0));
		else
			px.weight = 9'($urandom_range(511, 257));
		if (lim == 0 || $urandom_range(99, 0) < 12) begin
			if (lim < 65536 && $urandom_range(1, 0) == 1) begin
				px.command = 2'($urandom_range(3, 0));
				px.pixel_index = 16'($urandom_range(65535, lim));
			end else begin
				px.command = CMD_UNUSED;
				px.pixel_index = 16'($urandom_range(65535, 0));
			end
		end else begin
			if ($urandom_range(99, 0) < 80)
				idx = hot_pixels[$urandom_range(5, 0)];
			else
				idx = int'($urandom_range(lim - 1, 0));
			px.pixel_index = 16'(idx);
			roll = int'($urandom_range(99, 0));
			if (!pixel_acc.exists(idx) || roll < 20)
				px.command = CMD_CLEAR;
			else if (roll < 60)
				px.command = CMD_ADD;
			else
				px.command = CMD_READ;
		end
		return px;
	endfunction

	task automatic send_pixel(input wfa_in_t px, input bit typed, input wfa_out_t typed_rd);
		wfa_out_t rd;
		@(negedge clk);
		while ($urandom_range(99, 0) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do
			@(posedge clk);
		while (!in_ready);
		if (predict_blur(px, rd))
			expected_pixels.push_back(typed ? typed_rd : rd);
	endtask

	task automatic load_frame_size(input logic [FRAME_W-1:0] size);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(negedge clk);
		// Dropped transactions and clears leave no result but may still be in flight.
		repeat (PIPE_DRAIN) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= size;
		@(negedge clk);
		cfg_we <= 1'b0;
		frame_limit = size;
	endtask

	task automatic check_field(input string name, input int want, input logic [15:0] got);
		if (got !== 16'(want)) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		wfa_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected read-out, actual %p", $time, out_data);
				mismatch_count++;
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_out_index", want.pixel_out_index, out_data.pixel_out_index);
				check_field("chan0_out", want.chan0_out, 16'(out_data.chan0_out));
				check_field("chan1_out", want.chan1_out, 16'(out_data.chan1_out));
				check_field("chan2_out", want.chan2_out, 16'(out_data.chan2_out));
				check_field("chan3_out", want.chan3_out, 16'(out_data.chan3_out));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [FRAME_W-1:0] frame_sizes [9];
		int lim;
		int count;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		snd_idle_pct = 25;
		rcv_idle_pct = 61;
		frame_limit = FRAME_RESET;
		frame_sizes = '{17'd16, 17'd1, 17'd0, 17'd9, 17'd131071, 17'd65536, 17'd24,
			17'd300, 17'd65535};
		directed_rows = '{
			'{pix(CMD_CLEAR, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255, 9'd256), 1'b0, '0},
			'{pix(CMD_READ, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b1,
				blurred(16'd0, 8'd255, 8'd255, 8'd255, 8'd255)},
			// 0xFF00 plus 0x0100 wraps every lane to zero.
			'{pix(CMD_ADD, 16'd0, 8'd1, 8'd1, 8'd1, 8'd1, 9'd256), 1'b0, '0},
			'{pix(CMD_READ, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b1,
				blurred(16'd0, 8'd0, 8'd0, 8'd0, 8'd0)},
			// A weight above 256 keeps only the low 16 bits of the product.
			'{pix(CMD_CLEAR, 16'hFFFF, 8'd255, 8'd0, 8'd255, 8'd0, 9'd511), 1'b0, '0},
			'{pix(CMD_READ, 16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b1,
				blurred(16'hFFFF, 8'd253, 8'd0, 8'd253, 8'd0)},
			'{pix(CMD_CLEAR, 16'd1, 8'd10, 8'd20, 8'd30, 8'd40, 9'd0), 1'b0, '0},
			'{pix(CMD_READ, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b1,
				blurred(16'd1, 8'd0, 8'd0, 8'd0, 8'd0)},
			'{pix(CMD_ADD, 16'd1, 8'd128, 8'd64, 8'd32, 8'd16, 9'd100), 1'b0, '0},
			'{pix(CMD_ADD, 16'd1, 8'd200, 8'd150, 8'd100, 8'd50, 9'd156), 1'b0, '0},
			'{pix(CMD_READ, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b0, '0},
			'{pix(CMD_UNUSED, 16'd1, 8'd255, 8'd255, 8'd255, 8'd255, 9'd511), 1'b0, '0},
			'{pix(CMD_READ, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b0, '0},
			'{pix(CMD_CLEAR, 16'd2, 8'h55, 8'hAA, 8'h0F, 8'hF0, 9'h155), 1'b0, '0},
			'{pix(CMD_ADD, 16'd2, 8'hAA, 8'h55, 8'hF0, 8'h0F, 9'h0AA), 1'b0, '0},
			'{pix(CMD_READ, 16'd2, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b0, '0},
			'{pix(CMD_CLEAR, 16'h5555, 8'd255, 8'd255, 8'd255, 8'd255, 9'd1), 1'b0, '0},
			'{pix(CMD_READ, 16'h5555, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b1,
				blurred(16'h5555, 8'd0, 8'd0, 8'd0, 8'd0)},
			'{pix(CMD_CLEAR, 16'hAAAA, 8'd1, 8'd2, 8'd3, 8'd4, 9'd256), 1'b0, '0},
			'{pix(CMD_READ, 16'hAAAA, 8'd0, 8'd0, 8'd0, 8'd0, 9'd0), 1'b1,
				blurred(16'hAAAA, 8'd1, 8'd2, 8'd3, 8'd4)},
			'{pix(CMD_UNUSED, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255, 9'd511), 1'b0, '0}
		};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].rd);

		for (int seg = 0; seg < 9; seg++) begin
			if (seg == 3) begin
				snd_idle_pct = 61;
				rcv_idle_pct = 25;
			end else if (seg == 6) begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			load_frame_size(frame_sizes[seg]);
			lim = (frame_limit > FRAME_W'(65536)) ? 65536 : int'(frame_limit);
			// Hot pixels sit at both ends of the frame and at random places inside it.
			if (lim > 0) begin
				hot_pixels[0] = 0;
				hot_pixels[1] = lim - 1;
				for (int h = 2; h < 6; h++)
					hot_pixels[h] = int'($urandom_range(lim - 1, 0));
			end
			count = (lim == 0) ? 20 : 90;
			repeat (count)
				send_pixel(next_pixel(), 1'b0, '0);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN + 2) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
